// ===== design/itoa_fmt_pkg.sv =====
// Shared types, constants and a helper function for the integer-to-ASCII formatter.
// No dependencies; every other file of the block refers to it by scoped names.
package itoa_fmt_pkg;

    // Format selector codes as they arrive on the op port.
    typedef enum logic [2:0] {
        OP_U8_DEC  = 3'd0,
        OP_S8_DEC  = 3'd1,
        OP_U16_DEC = 3'd2,
        OP_S16_DEC = 3'd3,
        OP_HEX2_UP = 3'd4,
        OP_HEX_LO  = 3'd5,
        OP_OCT     = 3'd6
    } t_op;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_HEX,
        BASE_OCT
    } t_base;

    // One classified job, as it sits in the queue between the two halves.
    typedef struct packed {
        logic [15:0] mag;
        t_base       base;
        logic        min2;
        logic        neg;
        logic        upper;
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_DIGIT,
        ST_SIGN,
        ST_EMIT
    } t_back_state;

    localparam int unsigned QUEUE_DEPTH_DEF = 2;
    localparam int unsigned MAX_DIGITS      = 6;
    localparam int unsigned DIG_CNT_W       = 3;

    // Reciprocal of ten scaled by 2^19; exact for every 16-bit dividend.
    localparam logic [15:0] RECIP_TEN   = 16'd52429;
    localparam int unsigned RECIP_SHIFT = 19;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] ch;
        begin
            if (d < 4'd10) begin
                ch = CHAR_ZERO + {4'b0, d};
            end else if (upper) begin
                ch = CHAR_UPPER + {4'b0, d} - 8'd10;
            end else begin
                ch = CHAR_LOWER + {4'b0, d} - 8'd10;
            end
            return ch;
        end
    endfunction

endpackage

// ===== design/integer_to_ascii_formatter_core.sv =====
// Top level of the integer-to-ASCII formatter: front classifier, job queue, back emitter.
// Depends on itoa_fmt_pkg, itoa_fmt_front, itoa_fmt_queue and itoa_fmt_back.
//
// A command is taken on a rising edge where start is high and busy is low; it carries
// a format code on i_op and a 16-bit value on i_value. The block answers with the ASCII
// characters of the value, most significant digit first, one per beat: each beat is shown
// on o_character and o_last for exactly one cycle with o_strobe high, and the receiver
// must take it then, as there is no way to hold beats off. o_last marks the final
// character of a value. Decimal formats drop leading zeros and put a minus sign first for
// negative values; the two-digit hex format always gives two upper-case digits; the
// lower-case hex and octal formats drop leading zeros. The unused format code is taken
// and produces no beats. For each item the emitter loads the job, then for each digit
// takes the quotient (a reciprocal multiply for decimal, a shift otherwise) and then the
// remainder, then sends a minus sign if there is one and then one character per digit;
// it takes no new job until the final character is out. The front half classifies a command
// in the cycle it arrives and places it in a short queue, so busy rises only when that
// queue is full and new commands can be taken while characters are still going out.
module integer_to_ascii_formatter_core #(
    parameter int unsigned QUEUE_DEPTH = itoa_fmt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_op,
    input  logic [15:0] i_value,
    output logic        o_strobe,
    output logic [7:0]  o_character,
    output logic        o_last
);

    itoa_fmt_pkg::t_job w_in_job;
    itoa_fmt_pkg::t_job w_out_job;
    logic               w_push;
    logic               w_pop;
    logic               w_empty;
    logic               w_full;

    // Commands are held off only while the queue has no free entry.
    assign busy = w_full;

    itoa_fmt_front u_front (
        .i_start (start),
        .i_busy  (busy),
        .i_op    (i_op),
        .i_value (i_value),
        .o_push  (w_push),
        .o_job   (w_in_job)
    );

    itoa_fmt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_in_job),
        .i_pop   (w_pop),
        .o_job   (w_out_job),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    itoa_fmt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!w_empty),
        .i_job       (w_out_job),
        .o_pop       (w_pop),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last)
    );

`ifndef SYNTH
    // A job that the front pushes must be waiting in the queue on the next cycle.
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !w_empty)
        else $error("queued job lost");

    // After the final character the emitter must reload before it sends anything more.
    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |=> !o_strobe)
        else $error("beat sent straight after a final character");

    // A minus sign always precedes at least one digit.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_character == itoa_fmt_pkg::CHAR_MINUS)) |-> !o_last)
        else $error("minus sign marked as final character");
`endif

endmodule

// ===== design/itoa_fmt_front.sv =====
// Front half of the formatter: takes a command and classifies it into a job.
// Depends on itoa_fmt_pkg for the op codes and the job structure.
module itoa_fmt_front (
    input  logic                 i_start,
    input  logic                 i_busy,
    input  logic [2:0]           i_op,
    input  logic [15:0]          i_value,
    output logic                 o_push,
    output itoa_fmt_pkg::t_job   o_job
);

    logic [7:0] w_lo;
    logic       w_known;

    assign w_lo = i_value[7:0];

    always_comb begin
        o_job.mag   = {8'b0, w_lo};
        o_job.base  = itoa_fmt_pkg::BASE_DEC;
        o_job.min2  = 1'b0;
        o_job.neg   = 1'b0;
        o_job.upper = 1'b0;
        w_known     = 1'b1;
        case (itoa_fmt_pkg::t_op'(i_op))
            itoa_fmt_pkg::OP_U8_DEC: begin
            end
            itoa_fmt_pkg::OP_S8_DEC: begin
                if (w_lo[7]) begin
                    o_job.mag = {7'b0, 9'(9'd256 - {1'b0, w_lo})};
                    o_job.neg = 1'b1;
                end
            end
            itoa_fmt_pkg::OP_U16_DEC: begin
                o_job.mag = i_value;
            end
            itoa_fmt_pkg::OP_S16_DEC: begin
                o_job.mag = i_value;
                if (i_value[15]) begin
                    o_job.mag = 16'(17'h10000 - {1'b0, i_value});
                    o_job.neg = 1'b1;
                end
            end
            itoa_fmt_pkg::OP_HEX2_UP: begin
                o_job.base  = itoa_fmt_pkg::BASE_HEX;
                o_job.min2  = 1'b1;
                o_job.upper = 1'b1;
            end
            itoa_fmt_pkg::OP_HEX_LO: begin
                o_job.mag  = i_value;
                o_job.base = itoa_fmt_pkg::BASE_HEX;
            end
            itoa_fmt_pkg::OP_OCT: begin
                o_job.mag  = i_value;
                o_job.base = itoa_fmt_pkg::BASE_OCT;
            end
            default: begin
                // The unused selector is taken but produces no characters.
                w_known = 1'b0;
            end
        endcase
    end

    assign o_push = i_start && !i_busy && w_known;

endmodule

// ===== design/itoa_fmt_queue.sv =====
// Short first-word-fall-through queue of classified jobs.
// Depends on itoa_fmt_pkg for the job structure.
module itoa_fmt_queue #(
    parameter int unsigned DEPTH = itoa_fmt_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  itoa_fmt_pkg::t_job   i_job,
    input  logic                 i_pop,
    output itoa_fmt_pkg::t_job   o_job,
    output logic                 o_empty,
    output logic                 o_full
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    itoa_fmt_pkg::t_job r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count,  n_count;
    logic               w_do_push, w_do_pop;

    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == CNT_W'(DEPTH));
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_job     = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

// ===== design/itoa_fmt_back.sv =====
// Back half of the formatter: turns a job into digits and sends the characters.
// Depends on itoa_fmt_pkg for the job structure, states and character helpers.
module itoa_fmt_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_job_valid,
    input  itoa_fmt_pkg::t_job   i_job,
    output logic                 o_pop,
    output logic                 o_strobe,
    output logic [7:0]           o_character,
    output logic                 o_last
);

    localparam int unsigned CW = itoa_fmt_pkg::DIG_CNT_W;

    itoa_fmt_pkg::t_back_state r_state, n_state;
    logic [15:0]               r_mag;
    logic [15:0]               r_quot,  n_quot;
    itoa_fmt_pkg::t_base       r_base;
    logic                      r_min2, r_neg, r_upper;
    logic [CW-1:0]             r_cnt;
    logic [3:0]                r_dig [itoa_fmt_pkg::MAX_DIGITS];
    logic [31:0]               w_prod;
    logic [15:0]               w_qb;
    logic [3:0]                w_digit;
    logic                      w_more;
    logic [CW-1:0]             w_rd_idx;

    // Quotient step: reciprocal multiply for decimal, plain shifts otherwise.
    assign w_prod = {16'b0, r_mag} * {16'b0, itoa_fmt_pkg::RECIP_TEN};

    always_comb begin
        case (r_base)
            itoa_fmt_pkg::BASE_DEC: n_quot = 16'(w_prod >> itoa_fmt_pkg::RECIP_SHIFT);
            itoa_fmt_pkg::BASE_HEX: n_quot = r_mag >> 4;
            itoa_fmt_pkg::BASE_OCT: n_quot = r_mag >> 3;
            default:                n_quot = r_mag;
        endcase
    end

    // Remainder step: digit = mag - quotient * base, with shifts and adds.
    always_comb begin
        case (r_base)
            itoa_fmt_pkg::BASE_DEC: w_qb = (r_quot << 3) + (r_quot << 1);
            itoa_fmt_pkg::BASE_HEX: w_qb = r_quot << 4;
            itoa_fmt_pkg::BASE_OCT: w_qb = r_quot << 3;
            default:                w_qb = r_quot;
        endcase
    end

    assign w_digit = 4'(r_mag - w_qb);
    assign w_more  = ((r_quot != '0) || (r_min2 && (r_cnt == '0)))
                  && ((r_cnt + 1'b1) < CW'(itoa_fmt_pkg::MAX_DIGITS));
    assign w_rd_idx = (r_cnt != '0) ? r_cnt - 1'b1 : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            itoa_fmt_pkg::ST_IDLE: begin
                if (i_job_valid) begin
                    n_state = itoa_fmt_pkg::ST_DIV;
                end
            end
            itoa_fmt_pkg::ST_DIV: begin
                n_state = itoa_fmt_pkg::ST_DIGIT;
            end
            itoa_fmt_pkg::ST_DIGIT: begin
                if (w_more) begin
                    n_state = itoa_fmt_pkg::ST_DIV;
                end else if (r_neg) begin
                    n_state = itoa_fmt_pkg::ST_SIGN;
                end else begin
                    n_state = itoa_fmt_pkg::ST_EMIT;
                end
            end
            itoa_fmt_pkg::ST_SIGN: begin
                n_state = itoa_fmt_pkg::ST_EMIT;
            end
            itoa_fmt_pkg::ST_EMIT: begin
                if (r_cnt == CW'(1)) begin
                    n_state = itoa_fmt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = itoa_fmt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        o_strobe    = 1'b0;
        o_character = '0;
        o_last      = 1'b0;
        case (r_state)
            itoa_fmt_pkg::ST_IDLE: begin
                o_pop = i_job_valid;
            end
            itoa_fmt_pkg::ST_SIGN: begin
                o_strobe    = 1'b1;
                o_character = itoa_fmt_pkg::CHAR_MINUS;
            end
            itoa_fmt_pkg::ST_EMIT: begin
                o_strobe    = 1'b1;
                o_character = itoa_fmt_pkg::digit_char(r_dig[w_rd_idx], r_upper);
                o_last      = (r_cnt == CW'(1));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itoa_fmt_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == itoa_fmt_pkg::ST_IDLE) begin
                r_cnt <= '0;
            end else if (r_state == itoa_fmt_pkg::ST_DIGIT) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (r_state == itoa_fmt_pkg::ST_EMIT) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == itoa_fmt_pkg::ST_IDLE && i_job_valid) begin
            r_mag   <= i_job.mag;
            r_base  <= i_job.base;
            r_min2  <= i_job.min2;
            r_neg   <= i_job.neg;
            r_upper <= i_job.upper;
        end else if (r_state == itoa_fmt_pkg::ST_DIV) begin
            r_quot <= n_quot;
        end else if (r_state == itoa_fmt_pkg::ST_DIGIT) begin
            r_dig[r_cnt] <= w_digit;
            r_mag        <= r_quot;
        end
    end

endmodule
